// ===== rtl/core/qpmw_pkg.sv =====
package qpmw_pkg;

  // Default cluster size, log2 bytes
  localparam int unsigned CLUSTER_LOG2_DEF = 16;

  // Upper bound on refcount sizing rounds
  localparam int unsigned FIX_ROUNDS = 64;

  // Header field values
  localparam logic [31:0] HDR_MAGIC      = 32'h514649FB;
  localparam logic [31:0] HDR_VERSION    = 32'd3;
  localparam logic [31:0] HDR_RC_ORDER   = 32'd4;
  localparam logic [31:0] HDR_LENGTH     = 32'd104;

  // L1/L2 entry flag: cluster refcount is exactly one
  localparam logic [63:0] COPIED_FLAG = 64'h8000_0000_0000_0000;

  // Header word positions (64-bit word index inside cluster 0)
  localparam logic [12:0] HW_MAGIC_VER   = 13'd0;
  localparam logic [12:0] HW_CLUSTER_LOG2 = 13'd2;
  localparam logic [12:0] HW_SIZE        = 13'd3;
  localparam logic [12:0] HW_L1_SIZE     = 13'd4;
  localparam logic [12:0] HW_L1_OFFSET   = 13'd5;
  localparam logic [12:0] HW_RT_OFFSET   = 13'd6;
  localparam logic [12:0] HW_RT_CLUSTERS = 13'd7;
  localparam logic [12:0] HW_RC_ORDER    = 13'd12;

  // Layout computation sequencer
  typedef enum logic [2:0] {
    LS_IDLE,
    LS_DIV,
    LS_BASE,
    LS_ITER,
    LS_FIN
  } layout_state_t;

  // Image regions in cluster order
  typedef enum logic [2:0] {
    RG_HDR,
    RG_RT,
    RG_RB,
    RG_L1,
    RG_L2,
    RG_DATA
  } region_t;

endpackage

// ===== rtl/core/qcow2_preallocated_metadata_words.sv =====
// Pipeline: a command accepted at a clock edge is loaded into the decode register at that
// edge, and the decoded word is then loaded into the result register while done rises with
// it. Throughput: one word per cycle while busy is low; the receiver cannot stall. A size
// write holds busy through LS_DIV, LS_BASE, LS_ITER once per refcount sizing round (2..64,
// usually 2 or 3) and LS_FIN, or through LS_DIV alone when the size is zero.
// Reset: synchronous, clears the size, the layout is invalid until a size is written.
module qcow2_preallocated_metadata_words #(
  parameter int unsigned CLUSTER_LOG2 = qpmw_pkg::CLUSTER_LOG2_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [50:0] virtual_size_bytes,
  // command
  input  logic        start,
  output logic        busy,
  input  logic [35:0] cluster_index,
  input  logic [12:0] word_index,
  // result
  output logic        done,
  output logic [63:0] word_data,
  output logic        error
);
  import qpmw_pkg::*;

  localparam int unsigned PTR_BITS = CLUSTER_LOG2 - 3;
  localparam int unsigned RC_SH    = CLUSTER_LOG2 - 1;
  localparam int unsigned TOT_W    = 53 - CLUSTER_LOG2;
  localparam int unsigned CMP_W    = (TOT_W > 36) ? TOT_W : 36;
  localparam int unsigned OFF_W    = CMP_W + PTR_BITS;
  localparam int unsigned ROUND_W  = $clog2(FIX_ROUNDS);
  localparam logic [50:0] SIZE_LOW = (51'd1 << CLUSTER_LOG2) - 51'd1;

  // ceil(a / 2^sh), sh is always a constant here
  function automatic logic [TOT_W-1:0] div_up(input logic [TOT_W-1:0] a,
                                              input int unsigned sh);
    logic [TOT_W-1:0] mask;
    mask = {TOT_W{1'b1}} >> (TOT_W - sh);
    return (a >> sh) + TOT_W'(|(a & mask));
  endfunction

  // ---------------------------------------------------------------
  // Layout state
  layout_state_t state, state_next;

  logic [50:0]        size_q;
  logic               layout_valid;
  logic [TOT_W-1:0]   data_cnt;
  logic [TOT_W-1:0]   l2_cnt;
  logic [TOT_W-1:0]   l1c_cnt;
  logic [TOT_W-1:0]   rt_cnt;
  logic [TOT_W-1:0]   rb_cnt;
  logic [TOT_W-1:0]   total_cnt;
  logic [TOT_W-1:0]   base_cnt;
  logic [TOT_W-1:0]   rb_first;
  logic [TOT_W-1:0]   l1_first;
  logic [TOT_W-1:0]   l2_first;
  logic [TOT_W-1:0]   data_first;
  logic [ROUND_W-1:0] round;

  logic               cfg_write;
  logic [TOT_W-1:0]   data_n;
  logic [TOT_W-1:0]   l1c_n;
  logic [TOT_W-1:0]   base_n;
  logic [TOT_W-1:0]   rb_n;
  logic [TOT_W-1:0]   rt_n;
  logic [TOT_W-1:0]   total_n;
  logic               round_last;

  logic               s1_valid;

  assign cfg_write = cfg_valid && cfg_ready;

  // Cluster counts of the fixed regions
  assign data_n = TOT_W'(size_q >> CLUSTER_LOG2) + TOT_W'(|(size_q & SIZE_LOW));
  assign l1c_n  = div_up(l2_cnt, PTR_BITS);
  assign base_n = TOT_W'(1) + l1c_n + l2_cnt + data_cnt;

  // One refcount sizing round; total_cnt holds base + rt + rb
  assign rb_n       = div_up(total_cnt, RC_SH);
  assign rt_n       = div_up(rb_n, PTR_BITS);
  assign total_n    = base_cnt + rt_n + rb_n;
  assign round_last = ((total_n == total_cnt) && (round != '0))
                      || (round == ROUND_W'(FIX_ROUNDS - 1));

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      LS_IDLE: if (cfg_write) state_next = LS_DIV;
      LS_DIV:  state_next = (size_q == '0) ? LS_IDLE : LS_BASE;
      LS_BASE: state_next = LS_ITER;
      LS_ITER: if (round_last) state_next = LS_FIN;
      LS_FIN:  state_next = LS_IDLE;
      default: state_next = LS_IDLE;
    endcase
  end

  // Sequencer outputs; a size write waits for the decode stage to drain and for start to be low
  always_comb begin
    busy      = 1'b1;
    cfg_ready = 1'b0;
    case (state)
      LS_IDLE: begin
        busy      = 1'b0;
        cfg_ready = !s1_valid && !start;
      end
      default: begin
        busy      = 1'b1;
        cfg_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= LS_IDLE;
      size_q       <= '0;
      layout_valid <= 1'b0;
      round        <= '0;
    end else begin
      state <= state_next;
      case (state)
        LS_IDLE: begin
          if (cfg_write) begin
            size_q       <= virtual_size_bytes;
            layout_valid <= 1'b0;
          end
        end
        LS_DIV: begin
          data_cnt <= data_n;
          l2_cnt   <= div_up(data_n, PTR_BITS);
        end
        LS_BASE: begin
          l1c_cnt   <= l1c_n;
          base_cnt  <= base_n;
          rt_cnt    <= TOT_W'(1);
          rb_cnt    <= TOT_W'(1);
          total_cnt <= base_n + TOT_W'(2);
          round     <= '0;
        end
        LS_ITER: begin
          rb_cnt    <= rb_n;
          rt_cnt    <= rt_n;
          total_cnt <= total_n;
          round     <= round + ROUND_W'(1);
        end
        LS_FIN: begin
          rb_first     <= TOT_W'(1) + rt_cnt;
          l1_first     <= TOT_W'(1) + rt_cnt + rb_cnt;
          l2_first     <= TOT_W'(1) + rt_cnt + rb_cnt + l1c_cnt;
          data_first   <= total_cnt - data_cnt;
          layout_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Decode stage: region, offset inside region, range checks
  logic             accept;
  logic [CMP_W-1:0] idx_x;
  logic             err_a;
  region_t          region_a;
  logic [CMP_W-1:0] rbase_a;
  logic [CMP_W-1:0] diff_a;

  logic             s1_err;
  logic             s1_wover;
  region_t          s1_region;
  logic [OFF_W-1:0] s1_off;
  logic [12:0]      s1_word;

  assign accept = start && !busy;
  assign idx_x  = CMP_W'(cluster_index);
  assign err_a  = !layout_valid || (idx_x >= CMP_W'(total_cnt));

  always_comb begin
    if (idx_x == '0) begin
      region_a = RG_HDR;
      rbase_a  = '0;
    end else if (idx_x < CMP_W'(rb_first)) begin
      region_a = RG_RT;
      rbase_a  = CMP_W'(1);
    end else if (idx_x < CMP_W'(l1_first)) begin
      region_a = RG_RB;
      rbase_a  = CMP_W'(rb_first);
    end else if (idx_x < CMP_W'(l2_first)) begin
      region_a = RG_L1;
      rbase_a  = CMP_W'(l1_first);
    end else if (idx_x < CMP_W'(data_first)) begin
      region_a = RG_L2;
      rbase_a  = CMP_W'(l2_first);
    end else begin
      region_a = RG_DATA;
      rbase_a  = CMP_W'(data_first);
    end
  end

  assign diff_a = idx_x - rbase_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_err    <= err_a;
      s1_wover  <= (word_index >> PTR_BITS) != '0;
      s1_region <= region_a;
      s1_off    <= {diff_a, PTR_BITS'(word_index)};
      s1_word   <= word_index;
    end
  end

  // ---------------------------------------------------------------
  // Word build stage
  logic [TOT_W-1:0] limit_b;
  logic [TOT_W-1:0] target_b;
  logic             ptr_ok;
  logic [63:0]      ptr_addr;
  logic [3:0]       rc_hit;
  logic [63:0]      rc_word;
  logic [63:0]      hdr_word;
  logic [63:0]      word_next;

  // Entry limit and first pointed-to cluster of each table region
  always_comb begin
    case (s1_region)
      RG_RT: begin
        limit_b  = rb_cnt;
        target_b = rb_first;
      end
      RG_L1: begin
        limit_b  = l2_cnt;
        target_b = l2_first;
      end
      RG_L2: begin
        limit_b  = data_cnt;
        target_b = data_first;
      end
      default: begin
        limit_b  = '0;
        target_b = '0;
      end
    endcase
  end

  assign ptr_ok   = s1_off < OFF_W'(limit_b);
  assign ptr_addr = (64'(target_b) + 64'(s1_off)) << CLUSTER_LOG2;

  // Four refcounts per word, one per existing cluster
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rc_hit[3-k] = {s1_off, 2'(k)} < (OFF_W + 2)'(total_cnt);
    end
  end

  assign rc_word = {16'(rc_hit[3]), 16'(rc_hit[2]), 16'(rc_hit[1]), 16'(rc_hit[0])};

  // Header fields
  always_comb begin
    case (s1_word)
      HW_MAGIC_VER:    hdr_word = {HDR_MAGIC, HDR_VERSION};
      HW_CLUSTER_LOG2: hdr_word = 64'(CLUSTER_LOG2);
      HW_SIZE:         hdr_word = 64'(data_cnt) << CLUSTER_LOG2;
      HW_L1_SIZE:      hdr_word = 64'(l2_cnt) & 64'h0000_0000_FFFF_FFFF;
      HW_L1_OFFSET:    hdr_word = 64'(l1_first) << CLUSTER_LOG2;
      HW_RT_OFFSET:    hdr_word = 64'd1 << CLUSTER_LOG2;
      HW_RT_CLUSTERS:  hdr_word = (64'(rt_cnt) & 64'h0000_0000_FFFF_FFFF) << 32;
      HW_RC_ORDER:     hdr_word = {HDR_RC_ORDER, HDR_LENGTH};
      default:         hdr_word = '0;
    endcase
  end

  always_comb begin
    word_next = '0;
    if (!s1_err && !s1_wover) begin
      case (s1_region)
        RG_HDR:  word_next = hdr_word;
        RG_RT:   word_next = ptr_ok ? ptr_addr : '0;
        RG_RB:   word_next = rc_word;
        RG_L1:   word_next = ptr_ok ? (ptr_addr | COPIED_FLAG) : '0;
        RG_L2:   word_next = ptr_ok ? (ptr_addr | COPIED_FLAG) : '0;
        default: word_next = '0;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      word_data <= word_next;
      error     <= s1_err;
    end
  end

  // ---------------------------------------------------------------
  // Checks
  a_done_after_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(s1_valid) && $past(start && !busy, 2))
    else $error("result without accepted command");

  a_result_layout: assert property (@(posedge clk) disable iff (rst)
    done |-> (error || layout_valid))
    else $error("result taken from an invalid layout");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && error) |-> (word_data == '0))
    else $error("error result carries data");

  a_busy_from_cfg: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(cfg_valid && cfg_ready))
    else $error("layout sequencer started without a size transaction");

endmodule

// ===== tb/qcow2_preallocated_metadata_words_tb.sv =====
module qcow2_preallocated_metadata_words_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qpmw_pkg::*;

  localparam int unsigned CB       = CLUSTER_LOG2_DEF;
  localparam bit [63:0]   CSIZE    = 64'd1 << CB;
  localparam bit [63:0]   PTRS     = 64'd1 << (CB - 3);
  localparam bit [63:0]   RCS      = 64'd1 << (CB - 1);
  localparam bit [63:0]   MAX_SIZE = 64'd1 << 50;
  localparam int          PHASES   = 10;
  localparam int          PHASE_WORDS = 100;

  typedef struct packed {
    logic [63:0] data;
    logic        err;
  } word_result_t;

  // One directed step: either a size write or a word request
  typedef struct packed {
    bit        is_cfg;
    bit [50:0] size;
    bit [35:0] cl;
    bit [12:0] wd;
    bit        typed;
    bit [63:0] exp_data;
    bit        exp_err;
  } dir_row_t;

  localparam int DIR_ROWS = 29;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [50:0] virtual_size_bytes;
  logic        start;
  logic        busy;
  logic [35:0] cluster_index;
  logic [12:0] word_index;
  logic        done;
  logic [63:0] word_data;
  logic        error;

  // Predicted image layout
  bit [63:0] lay_data, lay_l2, lay_l1c, lay_rt, lay_rb, lay_total;
  bit [63:0] rb0, l1_0, l2_0, d0;
  bit        lay_valid;

  word_result_t pending_words[$];
  int unsigned  mismatch_count = 0;

  qcow2_preallocated_metadata_words dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .virtual_size_bytes (virtual_size_bytes),
    .start              (start),
    .busy               (busy),
    .cluster_index      (cluster_index),
    .word_index         (word_index),
    .done               (done),
    .word_data          (word_data),
    .error              (error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Directed steps; rows with typed = 1 carry their expected word
  dir_row_t dir_rows [0:DIR_ROWS-1] = '{
    // zero size after reset, then the widest request
    '{1'b0, 51'd0, 36'd0, HW_MAGIC_VER, 1'b1, 64'd0, 1'b1},
    '{1'b0, 51'd0, 36'hF_FFFF_FFFF, 13'h1FFF, 1'b1, 64'd0, 1'b1},
    // one byte: six clusters, one of each kind
    '{1'b1, 51'd1, 36'd0, 13'd0, 1'b0, 64'd0, 1'b0},
    '{1'b0, 51'd0, 36'd0, HW_MAGIC_VER, 1'b1, {HDR_MAGIC, HDR_VERSION}, 1'b0},
    '{1'b0, 51'd0, 36'd0, 13'd1, 1'b1, 64'd0, 1'b0},
    '{1'b0, 51'd0, 36'd0, HW_CLUSTER_LOG2, 1'b1, 64'(CB), 1'b0},
    '{1'b0, 51'd0, 36'd0, HW_SIZE, 1'b1, CSIZE, 1'b0},
    '{1'b0, 51'd0, 36'd0, HW_L1_SIZE, 1'b1, 64'd1, 1'b0},
    '{1'b0, 51'd0, 36'd0, HW_L1_OFFSET, 1'b1, 3 * CSIZE, 1'b0},
    '{1'b0, 51'd0, 36'd0, HW_RT_OFFSET, 1'b1, CSIZE, 1'b0},
    '{1'b0, 51'd0, 36'd0, HW_RT_CLUSTERS, 1'b1, 64'd1 << 32, 1'b0},
    '{1'b0, 51'd0, 36'd0, HW_RC_ORDER, 1'b1, {HDR_RC_ORDER, HDR_LENGTH}, 1'b0},
    '{1'b0, 51'd0, 36'd0, 13'h1FFF, 1'b1, 64'd0, 1'b0},
    '{1'b0, 51'd0, 36'd1, 13'd0, 1'b0, 64'd0, 1'b0},
    '{1'b0, 51'd0, 36'd1, 13'd1, 1'b0, 64'd0, 1'b0},
    '{1'b0, 51'd0, 36'd2, 13'd0, 1'b0, 64'd0, 1'b0},
    '{1'b0, 51'd0, 36'd2, 13'd1, 1'b0, 64'd0, 1'b0},
    '{1'b0, 51'd0, 36'd3, 13'd0, 1'b0, 64'd0, 1'b0},
    '{1'b0, 51'd0, 36'd4, 13'd0, 1'b0, 64'd0, 1'b0},
    '{1'b0, 51'd0, 36'd5, 13'h1FFF, 1'b0, 64'd0, 1'b0},
    '{1'b0, 51'd0, 36'd6, 13'd0, 1'b1, 64'd0, 1'b1},
    // partial cluster rounds up
    '{1'b1, 51'd65537, 36'd0, 13'd0, 1'b0, 64'd0, 1'b0},
    '{1'b0, 51'd0, 36'd0, HW_SIZE, 1'b0, 64'd0, 1'b0},
    // largest size
    '{1'b1, 51'h4_0000_0000_0000, 36'd0, 13'd0, 1'b0, 64'd0, 1'b0},
    '{1'b0, 51'd0, 36'd0, HW_SIZE, 1'b1, MAX_SIZE, 1'b0},
    '{1'b0, 51'd0, 36'd0, HW_RT_CLUSTERS, 1'b0, 64'd0, 1'b0},
    '{1'b0, 51'd0, 36'hF_FFFF_FFFF, 13'd0, 1'b1, 64'd0, 1'b1},
    // back to zero size
    '{1'b1, 51'd0, 36'd0, 13'd0, 1'b0, 64'd0, 1'b0},
    '{1'b0, 51'd0, 36'd1, 13'd0, 1'b1, 64'd0, 1'b1}
  };

  function automatic bit [63:0] ceil_shift(bit [63:0] a, int unsigned sh);
    return (a >> sh) + ((a & ((64'd1 << sh) - 1)) != 0 ? 64'd1 : 64'd0);
  endfunction

  // Derive the preallocated layout from a size; refcount sizing iterates to a fixpoint
  function automatic void rebuild_layout(bit [63:0] size);
    bit [63:0] nd, nl2, nl1, nrb, nrt, tot, prev;
    int        rounds;
    {lay_data, lay_l2, lay_l1c, lay_rt, lay_rb, lay_total} = '0;
    lay_valid = 1'b0;
    rb0 = 64'd1;
    l1_0 = 64'd1;
    l2_0 = 64'd1;
    d0 = 64'd1;
    if (size == 0) return;
    nd  = ceil_shift(size, CB);
    nl2 = ceil_shift(nd, CB - 3);
    nl1 = ceil_shift(nl2 * 8, CB);
    nrb = 1;
    nrt = 1;
    tot = 0;
    prev = '1;
    rounds = 0;
    while (rounds < FIX_ROUNDS && tot != prev) begin
      prev = tot;
      tot = 1 + nrt + nrb + nl1 + nl2 + nd;
      nrb = ceil_shift(tot, CB - 1);
      nrt = ceil_shift(nrb * 8, CB);
      tot = 1 + nrt + nrb + nl1 + nl2 + nd;
      rounds++;
    end
    lay_data = nd;
    lay_l2 = nl2;
    lay_l1c = nl1;
    lay_rb = nrb;
    lay_rt = nrt;
    lay_total = tot;
    lay_valid = 1'b1;
    rb0 = 1 + nrt;
    l1_0 = rb0 + nrb;
    l2_0 = l1_0 + nl1;
    d0 = l2_0 + nl2;
  endfunction

  // Expected image word at (cluster, word) for the current layout
  function automatic word_result_t image_word(bit [35:0] idx, bit [12:0] w);
    word_result_t r;
    region_t      rg;
    bit [63:0]    e;
    r = '0;
    if (!lay_valid || 64'(idx) >= lay_total) begin
      r.err = 1'b1;
      return r;
    end
    if (64'(w) >= PTRS) return r;
    if (idx == 0) rg = RG_HDR;
    else if (idx < rb0) rg = RG_RT;
    else if (idx < l1_0) rg = RG_RB;
    else if (idx < l2_0) rg = RG_L1;
    else if (idx < d0) rg = RG_L2;
    else rg = RG_DATA;
    case (rg)
      RG_HDR: begin
        case (w)
          HW_MAGIC_VER:    r.data = {HDR_MAGIC, HDR_VERSION};
          HW_CLUSTER_LOG2: r.data = 64'(CB);
          HW_SIZE:         r.data = lay_data * CSIZE;
          HW_L1_SIZE:      r.data = {32'd0, lay_l2[31:0]};
          HW_L1_OFFSET:    r.data = l1_0 * CSIZE;
          HW_RT_OFFSET:    r.data = CSIZE;
          HW_RT_CLUSTERS:  r.data = {lay_rt[31:0], 32'd0};
          HW_RC_ORDER:     r.data = {HDR_RC_ORDER, HDR_LENGTH};
          default:         r.data = 64'd0;
        endcase
      end
      RG_RT: begin
        e = (idx - 1) * PTRS + w;
        if (e < lay_rb) r.data = (rb0 + e) * CSIZE;
      end
      RG_RB: begin
        // four 16-bit refcounts per word, first one in the top lane
        e = (idx - rb0) * RCS + 64'(w) * 4;
        for (int k = 0; k < 4; k++) begin
          if (e + k < lay_total) r.data |= 64'd1 << (48 - 16 * k);
        end
      end
      RG_L1: begin
        e = (idx - l1_0) * PTRS + w;
        if (e < lay_l2) r.data = ((l2_0 + e) * CSIZE) | COPIED_FLAG;
      end
      RG_L2: begin
        e = (idx - l2_0) * PTRS + w;
        if (e < lay_data) r.data = ((d0 + e) * CSIZE) | COPIED_FLAG;
      end
      default: r.data = 64'd0;
    endcase
    return r;
  endfunction

  function automatic bit [63:0] rnd_upto(bit [63:0] n);
    return {$urandom, $urandom} % (n + 1);
  endfunction

  function automatic bit [50:0] pick_size();
    bit [63:0] s;
    case ($urandom_range(0, 9))
      0: s = 64'd0;
      1: s = MAX_SIZE;
      2, 3: s = 64'($urandom_range(1, 1 << 22));
      // straddle an L2 table boundary
      4, 5: s = 64'($urandom_range(1, 64)) * (PTRS * CSIZE)
                + 64'($urandom_range(0, 2)) * CSIZE - CSIZE;
      default: s = 1 + rnd_upto(MAX_SIZE - 1);
    endcase
    return s[50:0];
  endfunction

  // Mostly metadata clusters and region edges, some data, some past the end
  function automatic bit [35:0] pick_cluster();
    int        r;
    bit [63:0] c;
    if (!lay_valid) return 36'({$urandom, $urandom});
    r = $urandom_range(0, 99);
    if (r < 10) c = 0;
    else if (r < 55) c = rnd_upto((d0 + 1 < lay_total) ? d0 + 1 : lay_total - 1);
    else if (r < 65) begin
      case ($urandom_range(0, 4))
        0: c = 1;
        1: c = rb0;
        2: c = l1_0;
        3: c = l2_0;
        default: c = d0;
      endcase
      c = c - $urandom_range(0, 1);
    end
    else if (r < 80) c = d0 + rnd_upto(lay_total - 1 - d0);
    else if (r < 92) c = lay_total - 2 + $urandom_range(0, 3);
    else c = {$urandom, $urandom};
    return c[35:0];
  endfunction

  // Favor words around the last live entry of a table cluster
  function automatic bit [12:0] pick_word(bit [35:0] idx);
    longint tail;
    int     r;
    r = $urandom_range(0, 3);
    if (r == 0) return 13'($urandom);
    if (r == 1) return 13'($urandom_range(0, 15));
    tail = -1;
    if (lay_valid && idx != 0 && 64'(idx) < d0) begin
      if (idx < rb0) tail = longint'(lay_rb) - longint'(idx - 1) * longint'(PTRS);
      else if (idx < l1_0)
        tail = (longint'(lay_total) - longint'(idx - rb0) * longint'(RCS)) / 4;
      else if (idx < l2_0) tail = longint'(lay_l2) - longint'(idx - l1_0) * longint'(PTRS);
      else tail = longint'(lay_data) - longint'(idx - l2_0) * longint'(PTRS);
    end
    tail = tail - 1 + $urandom_range(0, 2);
    if (tail < 0 || tail >= longint'(PTRS)) return 13'($urandom);
    return 13'(tail);
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // One request transaction; start is left high for a following word
  task automatic issue_word(bit [35:0] c, bit [12:0] w, bit typed, word_result_t want);
    @(negedge clk);
    start <= 1'b1;
    cluster_index <= c;
    word_index <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_words.push_back(typed ? want : image_word(c, w));
  endtask

  task automatic drop_start_and_drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // Size write only once the block has gone quiet
  task automatic write_size(bit [50:0] s);
    drop_start_and_drain();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    virtual_size_bytes <= s;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    rebuild_layout(64'(s));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result checker: every done pops the oldest expected word
  always @(posedge clk) begin : check_results
    word_result_t want;
    if (!rst && done) begin
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: data %h err %b",
                                  word_data, error));
      end else begin
        want = pending_words.pop_front();
        if (word_data !== want.data)
          report_mismatch($sformatf("word_data %h, expected %h", word_data, want.data));
        if (error !== want.err)
          report_mismatch($sformatf("error %b, expected %b", error, want.err));
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    dir_row_t row;
    int       sent, blen, gap, wait_cycles;
    bit [35:0] c;
    rst = 1'b1;
    cfg_valid = 1'b0;
    virtual_size_bytes = '0;
    start = 1'b0;
    cluster_index = '0;
    word_index = '0;
    rebuild_layout(64'd0);
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_rows[i];
      if (row.is_cfg) write_size(row.size);
      else issue_word(row.cl, row.wd, row.typed, {row.exp_data, row.exp_err});
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      write_size(pick_size());
      sent = 0;
      while (sent < PHASE_WORDS) begin
        blen = $urandom_range(1, 24);
        for (int j = 0; j < blen && sent < PHASE_WORDS; j++) begin
          c = pick_cluster();
          issue_word(c, pick_word(c), 1'b0, '0);
          sent++;
        end
        if ($urandom_range(0, 15) == 0) begin
          drop_start_and_drain();
        end else begin
          gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          if (gap > 0) begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
          end
        end
      end
    end

    // Drain, then wait on for anything stray
    @(negedge clk);
    start <= 1'b0;
    wait_cycles = 0;
    while (pending_words.size() != 0 && wait_cycles < 1000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (8) @(posedge clk);
    if (pending_words.size() != 0)
      report_mismatch($sformatf("%0d expected words never arrived", pending_words.size()));

    if (mismatch_count == 0) begin
      $display("qcow2_preallocated_metadata_words_tb passed");
    end else begin
      $display("qcow2_preallocated_metadata_words_tb failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("qcow2_preallocated_metadata_words_tb failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/qpmw_pkg.sv
rtl/core/qcow2_preallocated_metadata_words.sv
tb/qcow2_preallocated_metadata_words_tb.sv
